/* sv/lks_pkg.sv */
// Shared types and codes for the LRU key set.
package lks_pkg;

   localparam int REQ_FIELD_BITS = 2;
   localparam int KEY_FIELD_BITS = 32;
   localparam int OCC_FIELD_BITS = 5;
   localparam int CAP_FIELD_BITS = 5;

   // Request kinds; the fourth code is unused and changes nothing.
   localparam logic [REQ_FIELD_BITS-1:0] REQ_LOOKUP = 2'd0;
   localparam logic [REQ_FIELD_BITS-1:0] REQ_ADD    = 2'd1;
   localparam logic [REQ_FIELD_BITS-1:0] REQ_REMOVE = 2'd2;

   typedef struct packed {
      logic [REQ_FIELD_BITS-1:0] req_type;
      logic [KEY_FIELD_BITS-1:0] key;
   } lks_req_type;

   typedef struct packed {
      logic                      hit;
      logic                      evicted;
      logic [KEY_FIELD_BITS-1:0] evicted_key;
      logic [OCC_FIELD_BITS-1:0] occupancy;
   } lks_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } lks_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PROMOTE,
      OP_EVICT,
      OP_INSERT,
      OP_REMOVE
   } lks_op_type;

   typedef struct packed {
      logic       capture;
      logic       match;
      logic       commit;
      lks_op_type op;
   } lks_cmd_type;

   typedef struct packed {
      logic [REQ_FIELD_BITS-1:0] req_type;
      logic                      hit;
      logic                      full;
      logic                      out_free;
   } lks_status_type;

endpackage

/* sv/lru_key_set.sv */
// LRU key set: fully associative key store with recency order and capacity limit.
//
// Request channel (req_valid/req_ready/req_data): one lookup, add or remove per
// request. Response channel (rsp_valid/rsp_ready/rsp_data): exactly one response
// per request, in order: hit, eviction flag and key, occupancy after the request.
// Config channel (csr_valid/csr_ready/csr_data): capacity limit, always ready;
// write it only while no request is in flight. Zero acts as one, values above
// ENTRIES act as ENTRIES.
// Timing: a request is taken in the idle cycle, compared against all slots in the
// next, and ranks are updated and the response registered in the update step.
// One request is worked at a time: a new request is not taken until the
// capture/match/update sequence of the last one is through.
// The next request is accepted while a response still sits in the output
// register; if the receiver keeps stalling, the following request waits in the
// update step until the register drains, and req_ready stays low meanwhile.
// Reset (synchronous, active high) empties the set, clears all ranks and sets
// the capacity to 16 (or ENTRIES if smaller). Stored keys are not cleared; they
// are only read behind their valid bits.
module lru_key_set import lks_pkg::*; #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lks_req_type               req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lks_rsp_type               rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CAP_FIELD_BITS-1:0] csr_data
);

   lks_cmd_type    cmd;
   lks_status_type status;

   // capacity register never back-pressures
   assign csr_ready = 1'b1;

   lks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lks_dp #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // one request in flight: no second accept right after the first
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // a response is loaded only when the output register is free or draining
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || rsp_ready))
      else $error("pending response overwritten");

   // an eviction only happens on a miss and leaves the set non-empty
   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.evicted) |-> (!rsp_data.hit && (rsp_data.occupancy != '0)))
      else $error("eviction reported on a hit or with an empty set");

   // occupancy never exceeds the slot count
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_data.occupancy) <= ENTRIES))
      else $error("occupancy above slot count");

endmodule

/* sv/lks_ctrl.sv */
// Request sequencer for the LRU key set: capture, match, update.
module lks_ctrl import lks_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  lks_status_type status,
   output lks_cmd_type    cmd
);

   lks_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.match   = 1'b0;
      cmd.commit  = 1'b0;
      cmd.op      = OP_NONE;
      case (status.req_type)
         REQ_LOOKUP: begin
            cmd.op = status.hit ? OP_PROMOTE : OP_NONE;
         end
         REQ_ADD: begin
            if (status.hit) begin
               cmd.op = OP_PROMOTE;
            end else if (status.full) begin
               cmd.op = OP_EVICT;
            end else begin
               cmd.op = OP_INSERT;
            end
         end
         REQ_REMOVE: begin
            cmd.op = status.hit ? OP_REMOVE : OP_NONE;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the result register can take the new response
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/lks_dp.sv */
// Key store, recency ranks, match logic and result register of the LRU key set.
module lks_dp import lks_pkg::*; #(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lks_req_type               req_data,
   input  logic                      csr_valid,
   input  logic [CAP_FIELD_BITS-1:0] csr_data,
   input  lks_cmd_type               cmd,
   output lks_status_type            status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lks_rsp_type               rsp_data
);

   localparam int IW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW        = $clog2(ENTRIES + 1);
   localparam int CAP_RESET = (ENTRIES < 16) ? ENTRIES : 16;

   // request capture
   logic [KEY_BITS-1:0]       req_key_ff;
   logic [REQ_FIELD_BITS-1:0] req_kind_ff;

   // slot state
   logic [KEY_BITS-1:0] key_ff   [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [IW-1:0]       rank_ff  [ENTRIES];
   logic [IW-1:0]       rank_in  [ENTRIES];
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       cap_ff, cap_in;

   // match stage results
   logic                hit_ff, full_ff;
   logic [ENTRIES-1:0]  sel_ff;
   logic [IW-1:0]       sel_rank_ff;
   logic [KEY_BITS-1:0] vkey_ff;

   logic [ENTRIES-1:0]  match_oh, victim_oh, free_oh, sel_oh;
   logic                hit_c, full_c, free_seen;
   logic [IW-1:0]       sel_rank_c;
   logic [KEY_BITS-1:0] vkey_c;

   lks_rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff;

   // effective capacity: zero reads as one, large values clamp to the slot count
   always_comb begin
      if (csr_data == '0) begin
         cap_in = CW'(1);
      end else if (int'(csr_data) > ENTRIES) begin
         cap_in = CW'(ENTRIES);
      end else begin
         cap_in = CW'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CW'(CAP_RESET);
      end else if (csr_valid) begin
         cap_ff <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_key_ff  <= KEY_BITS'(req_data.key);
         req_kind_ff <= req_data.req_type;
      end
   end

   // parallel compare; ranks of valid slots are a permutation of 0..count-1
   always_comb begin
      free_seen  = 1'b0;
      sel_rank_c = '0;
      vkey_c     = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_oh[i]  = valid_ff[i] && (key_ff[i] == req_key_ff);
         victim_oh[i] = valid_ff[i] && ((CW'(rank_ff[i]) + CW'(1)) == count_ff);
         free_oh[i]   = !valid_ff[i] && !free_seen;
         free_seen    = free_seen || !valid_ff[i];
      end
      hit_c  = |match_oh;
      full_c = (count_ff >= cap_ff);
      if (hit_c) begin
         sel_oh = match_oh;
      end else if (full_c) begin
         sel_oh = victim_oh;
      end else begin
         sel_oh = free_oh;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         sel_rank_c = sel_rank_c | ({IW{sel_oh[i]}} & rank_ff[i]);
         vkey_c     = vkey_c | ({KEY_BITS{victim_oh[i]}} & key_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         hit_ff      <= hit_c;
         full_ff     <= full_c;
         sel_ff      <= sel_oh;
         sel_rank_ff <= sel_rank_c;
         vkey_ff     <= vkey_c;
      end
   end

   // per-slot rank and valid update
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         case (cmd.op)
            OP_PROMOTE, OP_EVICT: begin
               if (sel_ff[i]) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < sel_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + IW'(1);
               end
            end
            OP_INSERT: begin
               if (sel_ff[i]) begin
                  rank_in[i]  = '0;
                  valid_in[i] = 1'b1;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + IW'(1);
               end
            end
            OP_REMOVE: begin
               if (sel_ff[i]) begin
                  rank_in[i]  = '0;
                  valid_in[i] = 1'b0;
               end else if (valid_ff[i] && (rank_ff[i] > sel_rank_ff)) begin
                  rank_in[i] = rank_ff[i] - IW'(1);
               end
            end
            default: begin
               rank_in[i] = rank_ff[i];
            end
         endcase
      end
      case (cmd.op)
         OP_INSERT: count_in = count_ff + CW'(1);
         OP_REMOVE: count_in = count_ff - CW'(1);
         default:   count_in = count_ff;
      endcase
      rsp_in.hit         = hit_ff;
      rsp_in.evicted     = (cmd.op == OP_EVICT);
      rsp_in.evicted_key = (cmd.op == OP_EVICT) ? KEY_FIELD_BITS'(vkey_ff) : '0;
      rsp_in.occupancy   = OCC_FIELD_BITS'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // key store: written only at the selected slot on insert or evict
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (cmd.commit && sel_ff[i] && ((cmd.op == OP_INSERT) || (cmd.op == OP_EVICT))) begin
            key_ff[i] <= req_key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.req_type = req_kind_ff;
   assign status.hit      = hit_ff;
   assign status.full     = full_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule
